// ===== src/spq_pkg.sv =====
// Shared types, constants and helpers for the stable priority queue.
// No dependencies; compile first.
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 32;

    localparam int PRI_W  = 8;
    localparam int TAG_W  = 32;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_off;
        logic [IDX_W-1:0] rd_off;
    } store_ctrl_t;

    // Ring position: head plus offset, folded back into 0 .. DEPTH-1
    function automatic logic [IDX_W-1:0] spq_wrap(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== src/spq_if.sv =====
// Request and result channel interfaces for the stable priority queue.
// Depends on spq_pkg.
interface spq_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [spq_pkg::PRI_W-1:0]  priority_req;
    logic [spq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, req_type, priority_req, tag, input ready);
    modport sink   (input valid, req_type, priority_req, tag, output ready);
endinterface

interface spq_res_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::PRI_W-1:0]  out_priority;
    logic [spq_pkg::TAG_W-1:0]  out_tag;
    logic [spq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_priority, out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_priority, out_tag, occupancy, output ready);
endinterface

// ===== src/spq_store.sv =====
// Entry store of the priority queue: a ring of (priority, tag) entries
// addressed relative to the head, one write and one registered read per cycle.
// Depends on spq_pkg.
module spq_store (
    input  logic                         clk,
    input  spq_pkg::store_ctrl_t         ctrl,
    input  logic [spq_pkg::IDX_W-1:0]    head,
    input  logic [spq_pkg::PRI_W-1:0]    wr_pri,
    input  logic [spq_pkg::TAG_BITS-1:0] wr_tag,
    output logic [spq_pkg::PRI_W-1:0]    rd_pri,
    output logic [spq_pkg::TAG_BITS-1:0] rd_tag
);
    import spq_pkg::*;

    logic [PRI_W-1:0]    pri_mem [DEPTH];
    logic [TAG_BITS-1:0] tag_mem [DEPTH];
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;

    assign wr_addr = spq_wrap(head, ctrl.wr_off);
    assign rd_addr = spq_wrap(head, ctrl.rd_off);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            pri_mem[wr_addr] <= wr_pri;
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_pri <= pri_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

endmodule

// ===== src/stable_priority_queue.sv =====
// Top level of the stable priority queue: request/result handshake, sequencer
// and ring pointers. Depends on spq_pkg, spq_if and spq_store.
//
// Bounded min-first priority queue of DEPTH entries. An insert request places
// (priority_req, tag) behind every held entry whose priority is not larger,
// so equal priorities leave in arrival order; a remove request pops the head.
// Each request gives exactly one result: status, the removed priority and tag
// (zero unless status is removed), and the occupancy after the request.
// Entries sit in a ring with one write and one registered read port. A remove
// advances the head pointer in S_POP and passes its result through S_DONE to
// the output register. An insert into a non-empty queue walks back from the
// tail one entry per cycle, moving each larger entry up one slot, until it
// meets an entry whose priority is not larger or places the new entry in the
// head slot. Full on insert, insert into an empty queue and empty on remove
// go straight from idle to S_DONE. The block takes one request at a time;
// req.ready is high only while the sequencer is idle, and a finished result
// waits in the output register without holding off the next request.
module stable_priority_queue (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_res_if.source res
);
    import spq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_POP   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;

    logic [PRI_W-1:0]    new_pri_reg, new_pri_next;
    logic [TAG_BITS-1:0] new_tag_reg, new_tag_next;
    status_t             pend_status_reg, pend_status_next;
    logic [PRI_W-1:0]    pend_pri_reg, pend_pri_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [PRI_W-1:0]    out_pri_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [OCC_W-1:0]    out_occ_reg;
    logic                out_load;

    store_ctrl_t         store_ctrl;
    logic [PRI_W-1:0]    wr_pri;
    logic [TAG_BITS-1:0] wr_tag;
    logic [PRI_W-1:0]    rd_pri;
    logic [TAG_BITS-1:0] rd_tag;

    logic                req_fire;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    spq_store u_store (
        .clk    (clk),
        .ctrl   (store_ctrl),
        .head   (head_reg),
        .wr_pri (wr_pri),
        .wr_tag (wr_tag),
        .rd_pri (rd_pri),
        .rd_tag (rd_tag)
    );

    // Sequencer: one compare and one entry move per cycle.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        new_pri_next     = new_pri_reg;
        new_tag_next     = new_tag_reg;
        pend_status_next = pend_status_reg;
        pend_pri_next    = pend_pri_reg;
        pend_tag_next    = pend_tag_reg;
        out_load         = 1'b0;

        store_ctrl.wr_en  = 1'b0;
        store_ctrl.wr_off = pos_reg;
        store_ctrl.rd_off = pos_reg - IDX_W'(1);
        wr_pri            = new_pri_reg;
        wr_tag            = new_tag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Prefetch the tail for an insert, the head for a remove.
                if (req.req_type == REQ_INSERT)
                begin
                    store_ctrl.rd_off = IDX_W'(count_reg - CNT_W'(1));
                end
                else
                begin
                    store_ctrl.rd_off = '0;
                end

                if (req_fire)
                begin
                    pend_pri_next = '0;
                    pend_tag_next = '0;
                    if (req.req_type == REQ_INSERT)
                    begin
                        new_pri_next = req.priority_req;
                        new_tag_next = TAG_BITS'(req.tag);
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            pend_status_next = ST_FULL;
                            state_next       = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            // Empty queue: drop the entry straight into the head slot.
                            store_ctrl.wr_en  = 1'b1;
                            store_ctrl.wr_off = '0;
                            wr_pri            = req.priority_req;
                            wr_tag            = TAG_BITS'(req.tag);
                            count_next        = count_reg + CNT_W'(1);
                            pend_status_next  = ST_INSERTED;
                            state_next        = S_DONE;
                        end
                        else
                        begin
                            pos_next   = IDX_W'(count_reg);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_status_next = ST_EMPTY;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // rd_pri/rd_tag hold the entry at pos - 1.
                if (rd_pri > new_pri_reg)
                begin
                    store_ctrl.wr_en  = 1'b1;
                    wr_pri            = rd_pri;
                    wr_tag            = rd_tag;
                    store_ctrl.rd_off = pos_reg - IDX_W'(2);
                    pos_next          = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    store_ctrl.wr_en = 1'b1;
                    count_next       = count_reg + CNT_W'(1);
                    pend_status_next = ST_INSERTED;
                    state_next       = S_DONE;
                end
            end

            S_PLACE:
            begin
                store_ctrl.wr_en = 1'b1;
                count_next       = count_reg + CNT_W'(1);
                pend_status_next = ST_INSERTED;
                state_next       = S_DONE;
            end

            S_POP:
            begin
                pend_status_next = ST_REMOVED;
                pend_pri_next    = rd_pri;
                pend_tag_next    = TAG_W'(rd_tag);
                head_next        = spq_wrap(head_reg, IDX_W'(1));
                count_next       = count_reg - CNT_W'(1);
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        new_pri_reg     <= new_pri_next;
        new_tag_reg     <= new_tag_next;
        pend_status_reg <= pend_status_next;
        pend_pri_reg    <= pend_pri_next;
        pend_tag_reg    <= pend_tag_next;
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_pri_reg    <= pend_pri_reg;
            out_tag_reg    <= pend_tag_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.out_priority = out_pri_reg;
    assign res.out_tag      = out_tag_reg;
    assign res.occupancy    = out_occ_reg;

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
module spq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [spq_pkg::STAT_W-1:0] status,
    input logic [spq_pkg::PRI_W-1:0]  out_priority,
    input logic [spq_pkg::TAG_W-1:0]  out_tag,
    input logic [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy)
            && $stable(out_priority) && $stable(out_tag))
        else $error("result changed while stalled");

    // One request at a time: busy after an accepted request.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty status with non-zero occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
        else $error("full status with wrong occupancy");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_REMOVED |-> out_priority == '0 && out_tag == '0)
        else $error("payload not zero outside a removal");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .status       (res.status),
    .out_priority (res.out_priority),
    .out_tag      (res.out_tag),
    .occupancy    (res.occupancy)
);
